### rtl/mrmq_pkg.sv
// Package with shared types and constants of the MIDI receive merging queue.
package mrmq_pkg;

    // Default ring depth; the chain holds one entry fewer than this.
    localparam int MRMQ_DEPTH = 16;

    // Action codes of an input item.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // One three-byte MIDI message.
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] key;
        logic [7:0] value;
    } t_msg;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic pop;
        logic push;
        logic any_hit;
        t_msg msg;
    } t_cell_ctl;

endpackage

### rtl/mrmq_in_if.sv
// Channel interface for the input items of the merging queue.
interface mrmq_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] status_byte;
    logic [7:0] key_byte;
    logic [7:0] value_byte;

    modport source (output valid, action, status_byte, key_byte, value_byte, input ready);
    modport sink   (input valid, action, status_byte, key_byte, value_byte, output ready);
endinterface

### rtl/mrmq_out_if.sv
// Channel interface for the result items of the merging queue.
interface mrmq_out_if;
    logic       valid;
    logic       ready;
    logic       popped_valid;
    logic [7:0] out_status;
    logic [7:0] out_key;
    logic [7:0] out_value;
    logic       merged;
    logic       dropped;

    modport source (output valid, popped_valid, out_status, out_key, out_value, merged,
                    dropped, input ready);
    modport sink   (input valid, popped_valid, out_status, out_key, out_value, merged,
                    dropped, output ready);
endinterface

### rtl/mrmq_cell.sv
// One queue cell: holds one pending message, matches it and shifts toward the head.
module mrmq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrmq_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_valid,
    input  logic               i_hit,
    input  logic               i_nb_valid,
    input  mrmq_pkg::t_msg     i_nb_msg,
    output logic               o_valid,
    output mrmq_pkg::t_msg     o_msg,
    output logic               o_hit
);
    import mrmq_pkg::*;

    logic r_valid;
    logic n_valid;
    t_msg r_msg;
    t_msg n_msg;
    logic match;

    // A cell matches when it holds a message with the same status and key.
    assign match = r_valid && (r_msg.status == i_ctl.msg.status)
                           && (r_msg.key == i_ctl.msg.key);
    assign o_hit = i_hit | match;

    // Pop shifts the whole chain by one; push merges into the oldest match
    // or appends into the first free cell.
    always_comb begin
        n_valid = r_valid;
        n_msg   = r_msg;
        if (i_ctl.pop) begin
            n_valid = i_nb_valid;
            n_msg   = i_nb_msg;
        end else if (i_ctl.push) begin
            if (i_ctl.any_hit) begin
                if (match && !i_hit) begin
                    n_msg.value = i_ctl.msg.value;
                end
            end else if (i_prev_valid && !r_valid) begin
                n_valid = 1'b1;
                n_msg   = i_ctl.msg;
            end
        end
    end

    // Valid bit is control state; the message needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_msg <= n_msg;
    end

    assign o_valid = r_valid;
    assign o_msg   = r_msg;

endmodule

### rtl/midi_receive_merging_queue.sv
// Top level of the MIDI receive merging queue: cell chain and result register.
//
// Use: input items arrive on i_in (valid/ready). Action 0 pushes a message
// (status, key, value); action 1 pops the oldest pending message. Each
// accepted item yields exactly one result item on o_out. A push whose status
// and key match a pending entry only replaces that entry's value (merged);
// when DEPTH-1 entries are pending an unmatched push is discarded (dropped).
// A pop on an empty queue returns all-zero fields.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless the receiver stalls; the pending
// entries sit in a chain of DEPTH-1 cells that all compare in the same
// cycle, and a pop shifts the whole chain one cell toward the head.
// Reset clears every cell's valid bit, so the queue starts empty, and clears
// the result valid bit; i_in.ready is low while reset is held. When the
// receiver stalls, the result waits in the output register and i_in.ready
// stays low until it is taken; ready is high again in the cycle the result
// is taken.
module midi_receive_merging_queue #(
    parameter int DEPTH = mrmq_pkg::MRMQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrmq_in_if.sink    i_in,
    mrmq_out_if.source o_out
);
    import mrmq_pkg::*;

    localparam int NCELL = DEPTH - 1;

    t_cell_ctl  ctl;
    logic       accept;
    logic       in_ready;
    logic       full;
    logic       any_hit;
    logic [NCELL-1:0] cell_valid;
    logic [NCELL-1:0] cell_hit;
    t_msg       cell_msg [NCELL];

    logic       r_out_valid;
    logic       r_popped_valid;
    t_msg       r_pop_msg;
    logic       r_merged;
    logic       r_dropped;

    // Input side is free out of reset when the result register is empty or being emptied.
    assign in_ready   = i_rst_n && (!r_out_valid || o_out.ready);
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    assign any_hit = cell_hit[NCELL-1];
    assign full    = cell_valid[NCELL-1];

    // Control broadcast to the cells.
    always_comb begin
        ctl.pop        = accept && (i_in.action == ACT_POP);
        ctl.push       = accept && (i_in.action == ACT_PUSH);
        ctl.any_hit    = any_hit;
        ctl.msg.status = i_in.status_byte;
        ctl.msg.key    = i_in.key_byte;
        ctl.msg.value  = i_in.value_byte;
    end

    // Chain of cells, oldest entry in cell zero.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic prev_valid;
        logic hit_in;
        logic nb_valid;
        t_msg nb_msg;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign hit_in     = 1'b0;
        end else begin : g_body
            assign prev_valid = cell_valid[g-1];
            assign hit_in     = cell_hit[g-1];
        end

        if (g == NCELL - 1) begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_msg   = '0;
        end else begin : g_inner
            assign nb_valid = cell_valid[g+1];
            assign nb_msg   = cell_msg[g+1];
        end

        mrmq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_prev_valid (prev_valid),
            .i_hit        (hit_in),
            .i_nb_valid   (nb_valid),
            .i_nb_msg     (nb_msg),
            .o_valid      (cell_valid[g]),
            .o_msg        (cell_msg[g]),
            .o_hit        (cell_hit[g])
        );
    end

    // Result register; valid is reset, the payload is loaded on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= i_in.valid;
        end
        if (accept) begin
            r_popped_valid <= ctl.pop && cell_valid[0];
            r_pop_msg      <= (ctl.pop && cell_valid[0]) ? cell_msg[0] : '0;
            r_merged       <= ctl.push && any_hit;
            r_dropped      <= ctl.push && !any_hit && full;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_valid = r_popped_valid;
    assign o_out.out_status   = r_pop_msg.status;
    assign o_out.out_key      = r_pop_msg.key;
    assign o_out.out_value    = r_pop_msg.value;
    assign o_out.merged       = r_merged;
    assign o_out.dropped      = r_dropped;

endmodule
